/* sv/handle_table_lookup_allocate_unit_defines.svh */
// ----------------------------------------------------------------------------
// Handle table assertion macros
// Shared property forms for the handle table checks.
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_LOOKUP_ALLOCATE_UNIT_DEFINES_SVH
`define HANDLE_TABLE_LOOKUP_ALLOCATE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HTLA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HTLA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/htla_pkg.sv */
// ----------------------------------------------------------------------------
// Handle table package
// Sizes, operation codes, request and response types, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package htla_pkg;

	localparam int SLOT_COUNT  = 256;
	localparam int KEY_W       = 64;
	localparam int HANDLE_W    = 8;
	localparam int HANDLE_SPAN = 256;
	localparam int IDX_W       = $clog2(SLOT_COUNT);
	localparam int SCAN_LAST   = ((SLOT_COUNT < HANDLE_SPAN) ? SLOT_COUNT : HANDLE_SPAN) - 1;

	typedef enum logic [1:0] {
		FUNC_GET,
		FUNC_LOOKUP,
		FUNC_FREE,
		FUNC_READ
	} func_t;

	typedef struct packed {
		func_t                func;
		logic [KEY_W-1:0]     object_key;
		logic [HANDLE_W-1:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]  handle;
		logic [KEY_W-1:0]     slot_key;
		logic                 status;
	} rsp_t;

	typedef struct packed {
		logic                 rd_en;
		logic [IDX_W-1:0]     rd_addr;
		logic                 wr_en;
		logic [IDX_W-1:0]     wr_addr;
		logic [KEY_W-1:0]     wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* sv/htla_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htla_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/htla_seq.sv */
// ----------------------------------------------------------------------------
// Handle table sequencer
// Slot scan with one key comparator, slot valid bits, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module htla_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire htla_pkg::req_t              req,
	input  wire logic                        req_fire,
	output logic                             idle,
	output logic                             res_valid,
	input  wire logic                        res_take,
	output htla_pkg::rsp_t                   res,
	output htla_pkg::mem_req_t               mem_req,
	input  wire logic [htla_pkg::KEY_W-1:0]  rd_data
);

	import htla_pkg::*;

	state_t                state_q;
	state_t                state_d;
	req_t                  req_q;
	rsp_t                  res_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [HANDLE_W-1:0]   cnt_q;
	logic                  issue_done_q;
	logic                  stg_v_s1;
	logic [HANDLE_W-1:0]   idx_s1;
	logic                  vld_s1;
	logic                  free_found_q;
	logic [HANDLE_W-1:0]   free_idx_q;

	logic                  in_range;
	logic [IDX_W-1:0]      slot_addr;
	logic                  key_match;
	logic                  slot_free;
	logic                  scan_end;
	logic                  free_now;
	logic [HANDLE_W-1:0]   free_pick;
	logic                  alloc;

	assign in_range  = (32'(req_q.slot_index) < SLOT_COUNT);
	assign slot_addr = IDX_W'(req_q.slot_index);
	assign key_match = stg_v_s1 && vld_s1 && (rd_data == req_q.object_key);
	assign slot_free = stg_v_s1 && !vld_s1;
	assign scan_end  = stg_v_s1 && (idx_s1 == HANDLE_W'(SCAN_LAST));
	assign free_now  = free_found_q || slot_free;
	assign free_pick = free_found_q ? free_idx_q : idx_s1;
	assign alloc     = (state_q == ST_SCAN) && !key_match && scan_end
		&& (req_q.func == FUNC_GET) && free_now;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				case (req_q.func)
					FUNC_GET, FUNC_LOOKUP: begin
						state_d = (req_q.object_key == '0) ? ST_DONE : ST_SCAN;
					end
					FUNC_FREE: state_d = ST_DONE;
					FUNC_READ: state_d = ST_READ;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (key_match || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req   = '0;
		idle      = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res       = res_q;
		case (state_q)
			ST_START: begin
				mem_req.rd_en   = (req_q.func == FUNC_READ) && in_range;
				mem_req.rd_addr = slot_addr;
			end
			ST_SCAN: begin
				mem_req.rd_en   = !issue_done_q;
				mem_req.rd_addr = IDX_W'(cnt_q);
				mem_req.wr_en   = alloc;
				mem_req.wr_addr = IDX_W'(free_pick);
				mem_req.wr_data = req_q.object_key;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			stg_v_s1     <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			stg_v_s1 <= (state_q == ST_SCAN) && !issue_done_q && !key_match && !scan_end;
			case (state_q)
				ST_START: begin
					cnt_q        <= HANDLE_W'(1);
					issue_done_q <= 1'b0;
					free_found_q <= 1'b0;
					if ((req_q.func == FUNC_FREE) && in_range) begin
						valid_q[slot_addr] <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!issue_done_q) begin
						cnt_q <= cnt_q + HANDLE_W'(1);
						if (cnt_q == HANDLE_W'(SCAN_LAST)) begin
							issue_done_q <= 1'b1;
						end
					end
					if (slot_free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (alloc) begin
						valid_q[IDX_W'(free_pick)] <= 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		case (state_q)
			ST_START: begin
				res_q  <= '0;
				vld_s1 <= in_range && valid_q[slot_addr];
			end
			ST_SCAN: begin
				idx_s1 <= cnt_q;
				vld_s1 <= valid_q[IDX_W'(cnt_q)];
				if (slot_free && !free_found_q) begin
					free_idx_q <= idx_s1;
				end
				if (key_match) begin
					res_q.handle <= idx_s1;
				end else if (scan_end) begin
					if (alloc) begin
						res_q.handle <= free_pick;
					end else begin
						res_q.status <= 1'b1;
					end
				end
			end
			ST_READ: begin
				res_q.slot_key <= vld_s1 ? rd_data : '0;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/handle_table_lookup_allocate_unit.sv */
// Free and null-key requests go from ST_START straight to ST_DONE; read passes through ST_READ.
// Get_handle and lookup scan the slots in ST_SCAN until a key match or slot n, at most 255.
// Throughput: one request at a time; one key compare per cycle bounds the slot scan.
// Reset: arst_n clears all slot valid bits at once, so every slot reads empty after reset.
// ----------------------------------------------------------------------------
// Handle table lookup and allocate unit
// Key table indexed by handle with lowest-free-slot allocation from slot 1 up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "handle_table_lookup_allocate_unit_defines.svh"

module handle_table_lookup_allocate_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire htla_pkg::req_t   req,
	input  wire logic             req_valid,
	output logic                  req_ready,
	output htla_pkg::rsp_t        rsp,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready
);

	import htla_pkg::*;

	logic             seq_idle;
	logic             res_valid;
	logic             res_take;
	rsp_t             res;
	mem_req_t         mem_req;
	logic [KEY_W-1:0] rd_data;
	logic             req_fire;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	assign req_ready = seq_idle;
	assign req_fire  = req_valid && req_ready;
	assign res_take  = res_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	htla_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_fire  (req_fire),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	htla_ram #(
		.WIDTH (KEY_W),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	`HTLA_ASSERT_NOW(a_no_slot0_alloc, mem_req.wr_en, mem_req.wr_addr != '0, "allocation into slot 0")
	`HTLA_ASSERT_NOW(a_no_null_store, mem_req.wr_en, mem_req.wr_data != '0, "null key stored")
	`HTLA_ASSERT_NOW(a_port_excl, mem_req.wr_en, !mem_req.rd_en, "table read and write together")
	`HTLA_ASSERT_NEXT(a_busy_after_req, req_fire, !req_ready, "ready right after request")

endmodule

`default_nettype wire
